// ===== src/abwh_pkg.sv =====
package abwh_pkg;

	localparam int BIN_COUNT_DEF = 21;
	localparam int SUM_WIDTH_DEF = 40;

	localparam int AGE_W     = 28;
	localparam int WEIGHT_W  = 24;
	localparam int BIN_W     = 6;
	localparam int OUT_SUM_W = 40;
	localparam int BW_W      = 16;
	localparam int MAX_AGE_W = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 20;
	localparam int FRAC_W    = 8;

	localparam logic [BW_W-1:0]      BIN_WIDTH_RST = 16'd1825;
	localparam logic [MAX_AGE_W-1:0] MAX_AGE_RST   = 20'd999999;

	localparam int CMDQ_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIN_WIDTH = 1'b0,
		CFG_MAX_AGE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_LOG  = 2'd0,
		CMD_ERR  = 2'd1,
		CMD_DUMP = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [BIN_W-1:0]    bin;
		logic [WEIGHT_W-1:0] weight;
		logic                infected;
		logic                new_inf;
	} cmd_t;

	typedef enum logic {
		F_IDLE = 1'b0,
		F_WORK = 1'b1
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE     = 2'd0,
		B_UPDATE   = 2'd1,
		B_DUMP_RD  = 2'd2,
		B_DUMP_OUT = 2'd3
	} back_state_t;

endpackage

// ===== src/abwh_front.sv =====
module abwh_front import abwh_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  action,
	input  logic [AGE_W-1:0]      age_q8,
	input  logic [WEIGHT_W-1:0]   weight_q16,
	input  logic                  is_infected,
	input  logic                  is_new_infection,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  q_push,
	output cmd_t                  q_cmd
);

	localparam int KW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int EW = BW_W + $clog2(BIN_COUNT + 1);
	localparam int CW = ((EW + FRAC_W) > AGE_W) ? (EW + FRAC_W) : AGE_W;
	localparam logic [KW-1:0] K_LAST = KW'(BIN_COUNT - 1);

	front_state_t state_q, state_d;

	logic [BW_W-1:0]      bin_width_q;
	logic [MAX_AGE_W-1:0] max_age_q;

	logic                action_q;
	logic [AGE_W-1:0]    age_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                inf_q;
	logic                newi_q;
	logic [KW-1:0]       k_q;
	logic [EW-1:0]       edge_q;

	logic accept;
	logic age_err;
	logic hit;
	logic done;
	logic step;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	assign age_err = age_q > {max_age_q, {FRAC_W{1'b0}}};
	assign hit     = CW'(age_q) <= CW'({edge_q, {FRAC_W{1'b0}}});
	assign done    = action_q || age_err || hit || (k_q == K_LAST);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_WORK;
			F_WORK: if (done && !q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full   = 1'b1;
		q_push = 1'b0;
		step   = 1'b0;
		q_cmd  = '{kind: CMD_LOG, bin: BIN_W'(k_q), weight: weight_q,
			infected: inf_q, new_inf: newi_q};
		priority if (action_q) begin
			q_cmd.kind = CMD_DUMP;
			q_cmd.bin  = '0;
		end else if (age_err) begin
			q_cmd.kind = CMD_ERR;
			q_cmd.bin  = '0;
		end else begin
			q_cmd.kind = CMD_LOG;
		end
		unique case (state_q)
			F_IDLE: full = 1'b0;
			F_WORK: begin
				q_push = done && !q_full;
				step   = !done;
			end
			default: full = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			bin_width_q <= BIN_WIDTH_RST;
			max_age_q   <= MAX_AGE_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_BIN_WIDTH: bin_width_q <= cfg_data[BW_W-1:0];
					CFG_MAX_AGE:   max_age_q   <= cfg_data[MAX_AGE_W-1:0];
					default:       max_age_q   <= max_age_q;
				endcase
			end
		end
	end

	// search walks one bin edge per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			age_q    <= age_q8;
			weight_q <= weight_q16;
			inf_q    <= is_infected;
			newi_q   <= is_new_infection;
			k_q      <= '0;
			edge_q   <= EW'(bin_width_q);
		end else if (step) begin
			k_q    <= k_q + KW'(1);
			edge_q <= edge_q + EW'(bin_width_q);
		end
	end

endmodule

// ===== src/abwh_cmdq.sv =====
module abwh_cmdq import abwh_pkg::*; #(
	parameter int DEPTH = CMDQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] P_LAST = PW'(DEPTH - 1);

	cmd_t            entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == NW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == P_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == P_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)      count_q <= count_q + NW'(1);
			else if (do_pop && !do_push) count_q <= count_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// ===== src/abwh_back.sv =====
module abwh_back import abwh_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF,
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  cmd_t                 q_cmd,
	output logic                 empty,
	input  logic                 pop,
	output logic [BIN_W-1:0]     bin_id,
	output logic [OUT_SUM_W-1:0] population_sum,
	output logic [OUT_SUM_W-1:0] infected_sum,
	output logic [OUT_SUM_W-1:0] new_infection_sum,
	output logic                 last_bin,
	output logic                 age_error
);

	localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int MW = 3 * SUM_WIDTH;
	localparam logic [AW-1:0] A_LAST = AW'(BIN_COUNT - 1);

	function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
			input logic [WEIGHT_W-1:0] w);
		logic [SUM_WIDTH:0] s;
		s = {1'b0, a} + (SUM_WIDTH + 1)'(w);
		return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
	endfunction

	back_state_t state_q, state_d;

	logic [MW-1:0]        mem [BIN_COUNT];
	logic [MW-1:0]        rd_data_q;
	logic [BIN_COUNT-1:0] valid_q;
	cmd_t                cur_q;
	logic [AW-1:0]       idx_q;

	logic                out_valid_q;
	logic [BIN_W-1:0]    out_bin_q;
	logic [OUT_SUM_W-1:0] out_pop_q;
	logic [OUT_SUM_W-1:0] out_inf_q;
	logic [OUT_SUM_W-1:0] out_newi_q;
	logic                out_last_q;
	logic                out_err_q;

	logic                out_free;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [MW-1:0]       wr_data;
	logic [AW-1:0]       cur_addr;
	logic                load_out;
	logic                clr_valid;
	logic                is_last;
	logic [MW-1:0]       upd_base;
	logic [MW-1:0]       dump_base;
	logic [SUM_WIDTH-1:0] new_pop;
	logic [SUM_WIDTH-1:0] new_inf;
	logic [SUM_WIDTH-1:0] new_newi;
	logic [BIN_W-1:0]    res_bin;
	logic [MW-1:0]       res_sums;
	logic                res_last;
	logic                res_err;

	assign out_free = !out_valid_q || pop;
	assign cur_addr = cur_q.bin[AW-1:0];
	assign is_last  = idx_q == A_LAST;

	// a bin never written since reset or the last dump reads as zero
	assign upd_base  = valid_q[cur_addr] ? rd_data_q : '0;
	assign dump_base = valid_q[idx_q] ? rd_data_q : '0;

	assign new_pop  = sat_add(upd_base[MW-1:2*SUM_WIDTH], cur_q.weight);
	assign new_inf  = cur_q.infected ?
		sat_add(upd_base[2*SUM_WIDTH-1:SUM_WIDTH], cur_q.weight) :
		upd_base[2*SUM_WIDTH-1:SUM_WIDTH];
	assign new_newi = cur_q.new_inf ?
		sat_add(upd_base[SUM_WIDTH-1:0], cur_q.weight) : upd_base[SUM_WIDTH-1:0];
	assign wr_data  = {new_pop, new_inf, new_newi};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					unique case (q_cmd.kind)
						CMD_LOG:  state_d = B_UPDATE;
						CMD_DUMP: state_d = B_DUMP_RD;
						default:  state_d = B_IDLE;
					endcase
				end
			end
			B_UPDATE:   state_d = B_IDLE;
			B_DUMP_RD:  state_d = B_DUMP_OUT;
			B_DUMP_OUT: if (out_free) state_d = is_last ? B_IDLE : B_DUMP_RD;
			default:    state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		load_out  = 1'b0;
		clr_valid = 1'b0;
		res_bin   = '0;
		res_sums  = '0;
		res_last  = 1'b0;
		res_err   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					unique case (q_cmd.kind)
						CMD_LOG: begin
							q_pop   = 1'b1;
							rd_en   = 1'b1;
							rd_addr = q_cmd.bin[AW-1:0];
						end
						CMD_ERR: begin
							q_pop    = out_free;
							load_out = out_free;
							res_last = 1'b1;
							res_err  = 1'b1;
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			B_UPDATE: wr_en = 1'b1;
			B_DUMP_RD: rd_en = 1'b1;
			B_DUMP_OUT: begin
				load_out  = out_free;
				clr_valid = out_free;
				res_bin   = BIN_W'(idx_q);
				res_sums  = dump_base;
				res_last  = is_last;
			end
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en)     valid_q[cur_addr] <= 1'b1;
			if (clr_valid) valid_q[idx_q]    <= 1'b0;
			if (state_q == B_IDLE) idx_q <= '0;
			else if (clr_valid && !is_last) idx_q <= idx_q + AW'(1);
			if (load_out)  out_valid_q <= 1'b1;
			else if (pop)  out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_cmd;
		if (load_out) begin
			out_bin_q  <= res_bin;
			out_pop_q  <= OUT_SUM_W'(res_sums[MW-1:2*SUM_WIDTH]);
			out_inf_q  <= OUT_SUM_W'(res_sums[2*SUM_WIDTH-1:SUM_WIDTH]);
			out_newi_q <= OUT_SUM_W'(res_sums[SUM_WIDTH-1:0]);
			out_last_q <= res_last;
			out_err_q  <= res_err;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[cur_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign empty             = !out_valid_q;
	assign bin_id            = out_bin_q;
	assign population_sum    = out_pop_q;
	assign infected_sum      = out_inf_q;
	assign new_infection_sum = out_newi_q;
	assign last_bin          = out_last_q;
	assign age_error         = out_err_q;

endmodule

// ===== src/age_binned_weighted_histogram_unit.sv =====
// A log item is classified by walking the bin edges, one bin edge per cycle, until it hits its bin or the last bin;
// then the update unit reads the bin from the sum memory, adds the weight and writes it back.
// An error result goes through the command queue to the output register; a dump reads each bin in B_DUMP_RD
// and presents it in B_DUMP_OUT, waiting while the output register is still held by the receiver.
// The front end takes a new item only once the last one is pushed; the command queue decouples both sides.
// Reset clears control state, loads default config and marks every bin empty via valid flags.
module age_binned_weighted_histogram_unit import abwh_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF,
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  action,
	input  logic [AGE_W-1:0]      age_q8,
	input  logic [WEIGHT_W-1:0]   weight_q16,
	input  logic                  is_infected,
	input  logic                  is_new_infection,
	output logic                  empty,
	input  logic                  pop,
	output logic [BIN_W-1:0]      bin_id,
	output logic [OUT_SUM_W-1:0]  population_sum,
	output logic [OUT_SUM_W-1:0]  infected_sum,
	output logic [OUT_SUM_W-1:0]  new_infection_sum,
	output logic                  last_bin,
	output logic                  age_error,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t fq_cmd;
	cmd_t qb_cmd;
	logic fq_push;
	logic fq_full;
	logic qb_pop;
	logic qb_empty;

	abwh_front #(
		.BIN_COUNT(BIN_COUNT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.action           (action),
		.age_q8           (age_q8),
		.weight_q16       (weight_q16),
		.is_infected      (is_infected),
		.is_new_infection (is_new_infection),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.q_full           (fq_full),
		.q_push           (fq_push),
		.q_cmd            (fq_cmd)
	);

	abwh_cmdq #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wr_cmd (fq_cmd),
		.full   (fq_full),
		.pop    (qb_pop),
		.rd_cmd (qb_cmd),
		.empty  (qb_empty)
	);

	abwh_back #(
		.BIN_COUNT (BIN_COUNT),
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (qb_empty),
		.q_pop             (qb_pop),
		.q_cmd             (qb_cmd),
		.empty             (empty),
		.pop               (pop),
		.bin_id            (bin_id),
		.population_sum    (population_sum),
		.infected_sum      (infected_sum),
		.new_infection_sum (new_infection_sum),
		.last_bin          (last_bin),
		.age_error         (age_error)
	);

endmodule

// ===== tb/tb_age_binned_weighted_histogram_unit.sv =====
module tb_age_binned_weighted_histogram_unit import abwh_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = BIN_COUNT_DEF;
	localparam int SW = SUM_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 2 * NB + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SAT_ITEMS = 4;

	localparam logic ACT_LOG  = 1'b0;
	localparam logic ACT_DUMP = 1'b1;

	typedef enum logic [1:0] {
		EXP_PREDICT,
		EXP_AGE_ERROR,
		EXP_EMPTY_DUMP
	} exp_kind_t;

	typedef struct {
		logic                act;
		logic [AGE_W-1:0]    age;
		logic [WEIGHT_W-1:0] weight;
		logic                inf;
		logic                newi;
		exp_kind_t           how;
	} hist_item_t;

	typedef struct {
		logic [BIN_W-1:0]     bin;
		logic [OUT_SUM_W-1:0] pop_s;
		logic [OUT_SUM_W-1:0] inf_s;
		logic [OUT_SUM_W-1:0] new_s;
		logic                 last;
		logic                 err;
	} bin_report_t;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic action = 1'b0;
	logic [AGE_W-1:0] age_q8 = '0;
	logic [WEIGHT_W-1:0] weight_q16 = '0;
	logic is_infected = 1'b0;
	logic is_new_infection = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [BIN_W-1:0] bin_id;
	logic [OUT_SUM_W-1:0] population_sum;
	logic [OUT_SUM_W-1:0] infected_sum;
	logic [OUT_SUM_W-1:0] new_infection_sum;
	logic last_bin;
	logic age_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [BW_W-1:0] width_days = BIN_WIDTH_RST;
	logic [MAX_AGE_W-1:0] max_days = MAX_AGE_RST;
	logic [SW-1:0] pop_store [NB];
	logic [SW-1:0] inf_store [NB];
	logic [SW-1:0] new_store [NB];

	bin_report_t step_reports[$];
	bin_report_t reports_due[$];

	int mismatches = 0;
	int reports_checked = 0;
	int logs_sent = 0;
	int dumps_sent = 0;
	int errors_sent = 0;
	int settings_used = 1;
	int stalled_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;

	hist_item_t directed_rows [13] = '{
		'{ACT_DUMP, 28'd0, 24'd0, 1'b0, 1'b0, EXP_EMPTY_DUMP},
		'{ACT_LOG, 28'd0, 24'hFFFFFF, 1'b1, 1'b1, EXP_PREDICT},
		'{ACT_LOG, 28'(1825 << 8), 24'd1, 1'b1, 1'b0, EXP_PREDICT},
		'{ACT_LOG, 28'((1825 << 8) + 1), 24'h800000, 1'b0, 1'b1, EXP_PREDICT},
		'{ACT_LOG, 28'((20 * 1825) << 8), 24'h123456, 1'b1, 1'b1, EXP_PREDICT},
		'{ACT_LOG, 28'(((20 * 1825) << 8) + 1), 24'd1, 1'b0, 1'b0, EXP_PREDICT},
		'{ACT_LOG, 28'(999999 << 8), 24'hABCDEF, 1'b1, 1'b0, EXP_PREDICT},
		'{ACT_LOG, 28'((999999 << 8) + 1), 24'hFFFFFF, 1'b1, 1'b1, EXP_AGE_ERROR},
		'{ACT_LOG, 28'hFFFFFFF, 24'h5A5A5A, 1'b0, 1'b1, EXP_AGE_ERROR},
		'{ACT_LOG, 28'd0, 24'd0, 1'b1, 1'b1, EXP_PREDICT},
		'{ACT_LOG, 28'd128, 24'h555555, 1'b0, 1'b0, EXP_PREDICT},
		'{ACT_DUMP, 28'hFFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, EXP_PREDICT},
		'{ACT_DUMP, 28'd0, 24'd0, 1'b0, 1'b0, EXP_EMPTY_DUMP}
	};

	age_binned_weighted_histogram_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.age_q8(age_q8),
		.weight_q16(weight_q16),
		.is_infected(is_infected),
		.is_new_infection(is_new_infection),
		.empty(empty),
		.pop(pop),
		.bin_id(bin_id),
		.population_sum(population_sum),
		.infected_sum(infected_sum),
		.new_infection_sum(new_infection_sum),
		.last_bin(last_bin),
		.age_error(age_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [SW-1:0] sat_sum(logic [SW-1:0] acc, logic [WEIGHT_W-1:0] w);
		logic [SW:0] s;
		s = {1'b0, acc} + (SW + 1)'(w);
		return s[SW] ? '1 : s[SW-1:0];
	endfunction

	// upper edge of bin k in Q.8 days
	function automatic logic [63:0] bin_edge(int k);
		if (k == NB - 1)
			return 64'(max_days) << 8;
		return (64'(k + 1) * 64'(width_days)) << 8;
	endfunction

	task automatic clear_histogram();
		for (int k = 0; k < NB; k++) begin
			pop_store[k] = '0;
			inf_store[k] = '0;
			new_store[k] = '0;
		end
	endtask

	task automatic histogram_step(input hist_item_t it);
		int b;
		bin_report_t rep;
		step_reports.delete();
		if (it.act == ACT_DUMP) begin
			for (int k = 0; k < NB; k++) begin
				rep = '{BIN_W'(k), pop_store[k], inf_store[k], new_store[k],
					k == NB - 1, 1'b0};
				step_reports.insert(step_reports.size(), rep);
			end
			clear_histogram();
		end else if (64'(it.age) > (64'(max_days) << 8)) begin
			rep = '{'0, '0, '0, '0, 1'b1, 1'b1};
			step_reports.insert(step_reports.size(), rep);
		end else begin
			b = NB - 1;
			for (int k = 0; k < NB - 1; k++) begin
				if (64'(it.age) <= bin_edge(k)) begin
					b = k;
					break;
				end
			end
			pop_store[b] = sat_sum(pop_store[b], it.weight);
			if (it.inf)
				inf_store[b] = sat_sum(inf_store[b], it.weight);
			if (it.newi)
				new_store[b] = sat_sum(new_store[b], it.weight);
		end
	endtask

	task automatic send_item(input hist_item_t it);
		int gap;
		bin_report_t rep;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= it.act;
		age_q8 <= it.age;
		weight_q16 <= it.weight;
		is_infected <= it.inf;
		is_new_infection <= it.newi;
		push <= 1'b1;
		do @(posedge clk); while (full);
		histogram_step(it);
		case (it.how)
			EXP_AGE_ERROR: begin
				rep = '{'0, '0, '0, '0, 1'b1, 1'b1};
				reports_due.insert(reports_due.size(), rep);
			end
			EXP_EMPTY_DUMP: begin
				for (int k = 0; k < NB; k++) begin
					rep = '{BIN_W'(k), '0, '0, '0, k == NB - 1, 1'b0};
					reports_due.insert(reports_due.size(), rep);
				end
			end
			default: begin
				foreach (step_reports[i])
					reports_due.insert(reports_due.size(), step_reports[i]);
			end
		endcase
		if (it.act == ACT_DUMP)
			dumps_sent++;
		else if (step_reports.size() != 0)
			errors_sent++;
		else
			logs_sent++;
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BIN_WIDTH)
			width_days = data[BW_W-1:0];
		else
			max_days = data[MAX_AGE_W-1:0];
	endtask

	// wait for all results plus the tail of any log still being classified
	task automatic settle();
		while (reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [AGE_W-1:0] pick_age();
		logic [63:0] top;
		logic [63:0] e;
		logic [63:0] a;
		top = 64'(max_days) << 8;
		case ($urandom_range(0, 9))
			0: a = 64'($urandom) & 64'hFFFFFFF;
			1: a = top + 64'($urandom_range(0, 2));
			2, 3, 4, 5: begin
				e = bin_edge(int'($urandom_range(0, NB - 1)));
				case ($urandom_range(0, 2))
					0: a = (e == 0) ? 64'd0 : e - 1;
					1: a = e;
					default: a = e + 1;
				endcase
			end
			default: a = 64'($urandom_range(0, 32'(top)));
		endcase
		if (a > 64'hFFFFFFF)
			a = 64'hFFFFFFF;
		return a[AGE_W-1:0];
	endfunction

	function automatic hist_item_t random_item();
		hist_item_t it;
		it.act = ($urandom_range(0, 11) == 0) ? ACT_DUMP : ACT_LOG;
		it.age = pick_age();
		case ($urandom_range(0, 7))
			0: it.weight = '0;
			1: it.weight = '1;
			default: it.weight = WEIGHT_W'($urandom);
		endcase
		it.inf = 1'($urandom_range(0, 1));
		it.newi = 1'($urandom_range(0, 1));
		it.how = EXP_PREDICT;
		return it;
	endfunction

	task automatic run_phase(input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] mx,
		input int n, input bit fast);
		hist_item_t it;
		settle();
		write_cfg(CFG_BIN_WIDTH, bw);
		write_cfg(CFG_MAX_AGE, mx);
		cfg_valid <= 1'b0;
		settings_used++;
		no_idle = fast;
		repeat (n) send_item(random_item());
		it = random_item();
		it.act = ACT_DUMP;
		send_item(it);
		push <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result side
	initial begin
		bin_report_t want;
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 8);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (reports_due.size() == 0) begin
				$error("result with nothing outstanding: bin_id %0d", bin_id);
				mismatches++;
			end else begin
				want = reports_due.pop_front();
				check_field("bin_id", 64'(want.bin), 64'(bin_id));
				check_field("population_sum", 64'(want.pop_s), 64'(population_sum));
				check_field("infected_sum", 64'(want.inf_s), 64'(infected_sum));
				check_field("new_infection_sum", 64'(want.new_s), 64'(new_infection_sum));
				check_field("last_bin", 64'(want.last), 64'(last_bin));
				check_field("age_error", 64'(want.err), 64'(age_error));
				reports_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					stalled_cycles, reports_due.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		hist_item_t it;
		clear_histogram();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i]);
		push <= 1'b0;

		// back-to-back full-scale weights into bin 0, new-infection flag on every other item, then one into bin 1 and a dump
		settle();
		no_idle = 1'b1;
		for (int i = 0; i < SAT_ITEMS; i++)
			send_item('{ACT_LOG, '0, '1, 1'b1, i[0], EXP_PREDICT});
		send_item('{ACT_LOG, 28'((1825 << 8) + 1), '1, 1'b1, 1'b1, EXP_PREDICT});
		send_item('{ACT_DUMP, '0, '0, 1'b0, 1'b0, EXP_PREDICT});
		push <= 1'b0;

		run_phase(20'd1, 20'd1, 70, 1'b0);
		run_phase(20'd65535, 20'hFFFFF, 70, 1'b1);
		run_phase(20'd0, 20'd500000, 60, 1'b0);
		// upper data bits are dropped by the bin width register; max sits below later edges
		run_phase(20'hF0003, 20'd40, 60, 1'b0);
		run_phase(20'd1825, 20'd999999, 70, 1'b0);

		// receiver holds off while dumps and errors pile up
		settle();
		hold_request = 1'b1;
		no_idle = 1'b1;
		for (int i = 0; i < 6; i++) begin
			it = random_item();
			it.act = (i % 2 == 0) ? ACT_DUMP : ACT_LOG;
			if (i == 1 || i == 5)
				it.age = '1;
			send_item(it);
		end
		push <= 1'b0;

		run_phase(CFG_DATA_W'($urandom_range(1, 65535)),
			CFG_DATA_W'($urandom_range(1, 20'hFFFFF)), 60, 1'b0);
		run_phase(CFG_DATA_W'($urandom_range(1, 65535)),
			CFG_DATA_W'($urandom_range(1, 20'hFFFFF)), 60, 1'b1);

		settle();
		$display("run covered %0d logs, %0d dumps and %0d out-of-range ages over %0d settings",
			logs_sent, dumps_sent, errors_sent, settings_used);
		$display("%0d bin reports checked, %0d mismatches", reports_checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
